@@ hw/rtl/lmrr_pkg.sv @@
`default_nettype none
package lmrr_pkg;

  localparam int unsigned NumLocks   = 16;
  localparam int unsigned NumClients = 16;
  localparam int unsigned QueueDepth = 8;
  localparam int unsigned LockW      = 4;
  localparam int unsigned ClientW    = 4;
  localparam int unsigned SlotW      = 3;
  localparam int unsigned CountW     = 4;

  typedef enum logic [1:0] {
    MODE_FREE     = 2'd0,
    MODE_LOCKED   = 2'd1,
    MODE_REVOKING = 2'd2,
    MODE_WAITING  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RETRY = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MSG_NONE   = 2'd0,
    MSG_REVOKE = 2'd1,
    MSG_RETRY  = 2'd2
  } msg_e;

  typedef enum logic {
    REQ_ACQUIRE = 1'b0,
    REQ_RELEASE = 1'b1
  } req_e;

  typedef enum logic {
    BS_READ = 1'b0,
    BS_EXEC = 1'b1
  } bstate_e;

  typedef struct packed {
    logic [0:0]         req_type;
    logic [LockW-1:0]   lock_id;
    logic [ClientW-1:0] client_id;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [1:0]         send_kind;
    logic [ClientW-1:0] send_client;
    logic [LockW-1:0]   send_lock;
  } rsp_t;

  typedef struct packed {
    logic valid;
    req_t item;
  } fq_out_t;

endpackage
`default_nettype wire

@@ hw/rtl/lmrr_front.sv @@
`default_nettype none
module lmrr_front import lmrr_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire req_t    in_word_i,
  output fq_out_t      fq_o,
  input  wire logic    pop_i
);

  req_t       ent_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic       pop;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (cnt_q != 2'd0);

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= in_word_i;
    end
  end

  assign fq_o.valid = (cnt_q != 2'd0);
  assign fq_o.item  = ent_q[rd_q];

endmodule
`default_nettype wire

@@ hw/rtl/lmrr_back.sv @@
`default_nettype none
module lmrr_back import lmrr_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire fq_out_t fq_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output rsp_t         out_word_o
);

  mode_e              mode_q  [NumLocks];
  logic [ClientW-1:0] owner_q [NumLocks];
  logic [SlotW-1:0]   head_q  [NumLocks];
  logic [CountW-1:0]  cnt_q   [NumLocks];
  logic [NumClients-1:0] mask_q [NumLocks];
  logic [ClientW-1:0] mem_q [NumLocks*QueueDepth];
  logic [ClientW-1:0] rdata_q;

  bstate_e state_q, state_d;
  logic    out_valid_q;
  rsp_t    out_word_q;
  logic    fire;

  logic [LockW-1:0]   lk;
  logic [ClientW-1:0] cl;
  mode_e              m;
  logic [SlotW-1:0]   hd;
  logic [CountW-1:0]  cn;
  logic               enq_ok;
  logic [SlotW-1:0]   slot;

  logic               do_enq, do_pop, wr_owner;
  mode_e              new_mode;
  logic [ClientW-1:0] new_owner;
  rsp_t               rsp;

  assign lk     = fq_i.item.lock_id;
  assign cl     = fq_i.item.client_id;
  assign m      = mode_q[lk];
  assign hd     = head_q[lk];
  assign cn     = cnt_q[lk];
  assign enq_ok = (cn < CountW'(QueueDepth)) && !mask_q[lk][cl];
  assign slot   = hd + cn[SlotW-1:0];
  assign fire   = (state_q == BS_EXEC) && (!out_valid_q || !out_stall_i);
  assign pop_o  = fire;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BS_READ: if (fq_i.valid) state_d = BS_EXEC;
      BS_EXEC: if (fire) state_d = BS_READ;
      default: state_d = BS_READ;
    endcase
  end

  always_comb begin
    do_enq    = 1'b0;
    do_pop    = 1'b0;
    wr_owner  = 1'b0;
    new_mode  = m;
    new_owner = owner_q[lk];
    rsp       = '{status: ST_ERROR, send_kind: MSG_NONE, send_client: '0, send_lock: '0};
    if (fq_i.item.req_type == REQ_ACQUIRE) begin
      case (m)
        MODE_FREE: begin
          wr_owner   = 1'b1;
          new_owner  = cl;
          new_mode   = MODE_LOCKED;
          rsp.status = ST_OK;
        end
        MODE_LOCKED: begin
          if (enq_ok) begin
            do_enq          = 1'b1;
            new_mode        = MODE_REVOKING;
            rsp.status      = ST_RETRY;
            rsp.send_kind   = MSG_REVOKE;
            rsp.send_client = owner_q[lk];
            rsp.send_lock   = lk;
          end
        end
        MODE_REVOKING: begin
          if (enq_ok) begin
            do_enq     = 1'b1;
            rsp.status = ST_RETRY;
          end
        end
        default: begin
          if ((cn != '0) && (rdata_q == cl)) begin
            do_pop     = 1'b1;
            wr_owner   = 1'b1;
            new_owner  = cl;
            rsp.status = ST_OK;
            if (cn == CountW'(1)) begin
              new_mode = MODE_LOCKED;
            end else begin
              new_mode        = MODE_REVOKING;
              rsp.send_kind   = MSG_REVOKE;
              rsp.send_client = cl;
              rsp.send_lock   = lk;
            end
          end else if (enq_ok) begin
            do_enq     = 1'b1;
            rsp.status = ST_RETRY;
          end
        end
      endcase
    end else if ((m == MODE_LOCKED || m == MODE_REVOKING) && owner_q[lk] == cl) begin
      wr_owner   = 1'b1;
      new_owner  = '0;
      rsp.status = ST_OK;
      if (m == MODE_LOCKED) begin
        new_mode = MODE_FREE;
      end else begin
        new_mode        = MODE_WAITING;
        rsp.send_kind   = MSG_RETRY;
        rsp.send_client = rdata_q;
        rsp.send_lock   = lk;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_READ;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumLocks; i++) begin
        mode_q[i]  <= MODE_FREE;
        owner_q[i] <= '0;
        head_q[i]  <= '0;
        cnt_q[i]   <= '0;
        mask_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (fire) begin
        out_valid_q <= 1'b1;
        mode_q[lk]  <= new_mode;
        if (wr_owner) owner_q[lk] <= new_owner;
        if (do_enq) begin
          cnt_q[lk]      <= cn + CountW'(1);
          mask_q[lk][cl] <= 1'b1;
        end
        if (do_pop) begin
          head_q[lk]     <= hd + SlotW'(1);
          cnt_q[lk]      <= cn - CountW'(1);
          mask_q[lk][cl] <= 1'b0;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_word_q <= rsp;
    end
    if (state_q == BS_READ) begin
      rdata_q <= mem_q[{lk, hd}];
    end
    if (fire && do_enq) begin
      mem_q[{lk, slot}] <= cl;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
`default_nettype wire

@@ hw/rtl/lock_manager_revoke_retry.sv @@
// A request word passes the request queue, then the back end's read and update states;
// the update loads the response register and waits while the output is stalled.
// One request at a time, the back end reads then updates lock table and waiter memory.
// A 2-entry request queue decouples intake; a response register holds the result.
// Reset (async, active low) frees every lock and empties every waiter queue at once.
`default_nettype none
module lock_manager_revoke_retry import lmrr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire req_t in_word_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output rsp_t      out_word_o
);

  fq_out_t fq;
  logic    pop;

  lmrr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .fq_o       (fq),
    .pop_i      (pop)
  );

  lmrr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fq_i        (fq),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  a_err_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == ST_ERROR |-> out_word_o.send_kind == MSG_NONE)
    else $error("error response carries a message");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.send_kind == MSG_NONE
      |-> out_word_o.send_client == '0 && out_word_o.send_lock == '0)
    else $error("message fields set without a message");

  a_pop_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> fq.valid)
    else $error("back end consumed an empty queue");

endmodule
`default_nettype wire
